[hdl/time_ordered_history_table_assert.svh]
// Assertion macros used by the history table search engine.
`ifndef TIME_ORDERED_HISTORY_TABLE_ASSERT_SVH
`define TIME_ORDERED_HISTORY_TABLE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define TOHT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define TOHT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/toht_pkg.sv]
// Types and constants of the time-ordered history table.
`default_nettype none
package toht_pkg;

    localparam int HISTORY_DEPTH_DEF = 64;

    localparam int ID_W      = 31;
    localparam int TIME_W    = 32;
    localparam int PAYLOAD_W = 64;
    localparam int FILL_W    = 7;

    typedef enum logic [1:0] {
        OP_APPEND    = 2'd0,
        OP_FIND_TIME = 2'd1,
        OP_FIND_ID   = 2'd2
    } op_e;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_COMPARE,
        ST_FINAL,
        ST_LAST
    } state_t;

    typedef struct packed {
        logic [1:0]           op;
        logic [ID_W-1:0]      key_id;
        logic [TIME_W-1:0]    key_time;
        logic [PAYLOAD_W-1:0] payload;
    } in_item_t;

    typedef struct packed {
        logic                 found;
        logic [ID_W-1:0]      rec_id;
        logic [TIME_W-1:0]    rec_time;
        logic [PAYLOAD_W-1:0] rec_payload;
        logic [FILL_W-1:0]    fill_count;
    } out_item_t;

    // One stored record, as laid out in the memory word.
    typedef struct packed {
        logic [ID_W-1:0]      id;
        logic [TIME_W-1:0]    stamp;
        logic [PAYLOAD_W-1:0] payload;
    } record_t;

    localparam int RECORD_W = $bits(record_t);

    // Search request handed from the front end to the search engine.
    typedef struct packed {
        logic              by_id;
        logic [TIME_W-1:0] key;
    } search_cmd_t;

endpackage
`default_nettype wire

[hdl/toht_ram.sv]
// Generic single-port RAM with registered read data.
`default_nettype none
module toht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    addr,
    input  wire logic [WIDTH-1:0] wdata,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule
`default_nettype wire

[hdl/toht_search.sv]
// Lower-bound binary search engine over the record memory.
`default_nettype none
`include "time_ordered_history_table_assert.svh"
module toht_search #(
    parameter int HISTORY_DEPTH = toht_pkg::HISTORY_DEPTH_DEF,
    parameter int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1,
    parameter int CW = $clog2(HISTORY_DEPTH + 1)
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cmd_valid,
    input  wire toht_pkg::search_cmd_t cmd,
    input  wire logic [CW-1:0]         total,
    input  wire logic [AW-1:0]         oldest,
    output logic      [AW-1:0]         rd_addr,
    input  wire toht_pkg::record_t     rd_data,
    output logic                       busy,
    output logic                       done,
    output toht_pkg::out_item_t        result
);
    import toht_pkg::*;

    localparam int SW = CW + 1;
    localparam logic [SW-1:0] DEPTH_S = SW'(HISTORY_DEPTH);

    state_t          state_reg, state_next;
    logic            by_id_reg, by_id_next;
    logic [TIME_W-1:0] key_reg, key_next;
    logic [CW-1:0]   base_reg, base_next;
    logic [CW-1:0]   len_reg, len_next;
    logic            done_reg, done_next;
    out_item_t       result_reg, result_next;

    logic [CW-1:0]     half;
    logic [CW-1:0]     mid;
    logic [CW-1:0]     pos_sel;
    logic [SW-1:0]     slot_sum;
    logic [SW-1:0]     slot_wrap;
    logic [TIME_W-1:0] probe;
    logic              hit;

    // Map a position in insertion order to its memory slot.
    assign half      = len_reg >> 1;
    assign mid       = base_reg + half;
    assign pos_sel   = (state_reg == ST_FINAL) ? base_reg : mid;
    assign slot_sum  = SW'(oldest) + SW'(pos_sel);
    assign slot_wrap = (slot_sum >= DEPTH_S) ? (slot_sum - DEPTH_S) : slot_sum;
    assign rd_addr   = slot_wrap[AW-1:0];

    assign probe = by_id_reg ? {1'b0, rd_data.id} : rd_data.stamp;
    assign hit   = by_id_reg ? (rd_data.id == key_reg[ID_W-1:0]) : 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        by_id_reg  <= by_id_next;
        key_reg    <= key_next;
        base_reg   <= base_next;
        len_reg    <= len_next;
        result_reg <= result_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        by_id_next  = by_id_reg;
        key_next    = key_reg;
        base_next   = base_reg;
        len_next    = len_reg;
        done_next   = 1'b0;
        result_next = result_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    by_id_next = cmd.by_id;
                    key_next   = cmd.key;
                    base_next  = '0;
                    len_next   = total;
                    state_next = (total != '0) ? ST_READ : ST_FINAL;
                end
            end
            ST_READ:
            begin
                state_next = ST_COMPARE;
            end
            ST_COMPARE:
            begin
                // Narrow the window to the upper or lower part.
                if (probe < key_reg)
                begin
                    base_next = mid + CW'(1);
                    len_next  = len_reg - half - CW'(1);
                end
                else
                begin
                    len_next = half;
                end
                state_next = (len_next != '0) ? ST_READ : ST_FINAL;
            end
            ST_FINAL:
            begin
                if (base_reg < total)
                begin
                    state_next = ST_LAST;
                end
                else
                begin
                    done_next              = 1'b1;
                    result_next.found       = 1'b0;
                    result_next.rec_id      = '0;
                    result_next.rec_time    = '0;
                    result_next.rec_payload = '0;
                    result_next.fill_count  = FILL_W'(total);
                    state_next             = ST_IDLE;
                end
            end
            ST_LAST:
            begin
                done_next               = 1'b1;
                result_next.found       = hit;
                result_next.rec_id      = hit ? rd_data.id : '0;
                result_next.rec_time    = hit ? rd_data.stamp : '0;
                result_next.rec_payload = hit ? rd_data.payload : '0;
                result_next.fill_count  = FILL_W'(total);
                state_next              = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    `TOHT_ASSERT_NOW(a_done_after_final, done_reg, ($past(state_reg == ST_FINAL) || $past(state_reg == ST_LAST)), "result strobe without a finishing search step")
    `TOHT_ASSERT_NOW(a_window_in_range, (state_reg != ST_IDLE), (({1'b0, base_reg} + {1'b0, len_reg}) <= {1'b0, total}), "search window runs past the fill count")
    `TOHT_ASSERT_NEXT(a_compare_moves_on, (state_reg == ST_COMPARE), ((state_reg == ST_READ) || (state_reg == ST_FINAL)), "compare step did not advance")
    `TOHT_ASSERT_NEXT(a_search_starts, ((state_reg == ST_IDLE) && cmd_valid), (state_reg != ST_IDLE), "accepted search left the engine idle")

endmodule
`default_nettype wire

[hdl/time_ordered_history_table.sv]
// Top level of the time-ordered history table.
// Records (id, timestamp, payload) sit in one record memory used as a ring
// ordered from oldest to newest. An append is taken while not busy and gives
// no result; when the table is full it overwrites the oldest record. A search
// runs a lower-bound binary search on the single memory port. Busy stays high
// through a read state and a compare state per halving step (at most
// floor(log2(fill)) + 1 steps, seven for 64 records), then a final state and
// a last read state; the last read is skipped when no record lies at or after
// the key, and an empty table goes straight to the final state.
// Its result shows in the first cycle with busy low. done is high for one
// cycle and the result must be taken then; there is no way to hold it.
// fill_count reports the record count modulo 128. An unused op code is taken
// and ignored.
`default_nettype none
module time_ordered_history_table #(
    parameter int HISTORY_DEPTH = toht_pkg::HISTORY_DEPTH_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire toht_pkg::in_item_t cmd,
    output logic                    done,
    output toht_pkg::out_item_t     result
);
    import toht_pkg::*;

    localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CW = $clog2(HISTORY_DEPTH + 1);
    localparam int SW = CW + 1;
    localparam logic [SW-1:0] DEPTH_S = SW'(HISTORY_DEPTH);

    logic [AW-1:0] oldest_reg, oldest_next;
    logic [CW-1:0] total_reg, total_next;

    logic          accept;
    logic          append;
    logic          full;
    logic [SW-1:0] tail_sum;
    logic [SW-1:0] tail_wrap;
    logic [SW-1:0] step_sum;
    logic [AW-1:0] wr_slot;
    logic [AW-1:0] search_addr;
    logic [AW-1:0] ram_addr;
    record_t       wr_rec;
    record_t       rd_rec;
    search_cmd_t   scmd;
    logic          search_go;

    assign accept    = start && !busy;
    assign append    = accept && (cmd.op == OP_APPEND);
    assign search_go = accept && ((cmd.op == OP_FIND_TIME) || (cmd.op == OP_FIND_ID));
    assign full      = (total_reg == CW'(HISTORY_DEPTH));

    // Slot after the newest record, and the oldest slot advanced by one.
    assign tail_sum  = SW'(oldest_reg) + SW'(total_reg);
    assign tail_wrap = (tail_sum >= DEPTH_S) ? (tail_sum - DEPTH_S) : tail_sum;
    assign step_sum  = SW'(oldest_reg) + SW'(1);
    assign wr_slot   = full ? oldest_reg : tail_wrap[AW-1:0];

    always_comb
    begin
        oldest_next = oldest_reg;
        total_next  = total_reg;
        if (append)
        begin
            if (full)
            begin
                oldest_next = (step_sum >= DEPTH_S) ? '0 : step_sum[AW-1:0];
            end
            else
            begin
                total_next = total_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oldest_reg <= '0;
            total_reg  <= '0;
        end
        else
        begin
            oldest_reg <= oldest_next;
            total_reg  <= total_next;
        end
    end

    assign wr_rec.id      = cmd.key_id;
    assign wr_rec.stamp   = cmd.key_time;
    assign wr_rec.payload = cmd.payload;

    assign scmd.by_id = (cmd.op == OP_FIND_ID);
    assign scmd.key   = (cmd.op == OP_FIND_ID) ? {1'b0, cmd.key_id} : cmd.key_time;

    // Appends own the port while idle; the search engine owns it while busy.
    assign ram_addr = busy ? search_addr : wr_slot;

    toht_ram #(
        .WIDTH (RECORD_W),
        .DEPTH (HISTORY_DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (append),
        .addr  (ram_addr),
        .wdata (wr_rec),
        .rdata (rd_rec)
    );

    toht_search #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .AW            (AW),
        .CW            (CW)
    ) u_search (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (search_go),
        .cmd       (scmd),
        .total     (total_reg),
        .oldest    (oldest_reg),
        .rd_addr   (search_addr),
        .rd_data   (rd_rec),
        .busy      (busy),
        .done      (done),
        .result    (result)
    );

endmodule
`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for the time-ordered history table.
`timescale 1ns / 1ps

module tb_top;
    import toht_pkg::*;

    localparam int RING_DEPTH = HISTORY_DEPTH_DEF;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 1350;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 40;
    localparam int REPORT_LIMIT = 10;
    localparam logic [ID_W-1:0] ID_MAX = '1;
    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    in_item_t cmd = '0;
    logic busy;
    logic done;
    out_item_t result;

    time_ordered_history_table uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mirror of the record ring, updated as each transaction is accepted.
    logic [ID_W-1:0]      ring_id      [RING_DEPTH];
    logic [TIME_W-1:0]    ring_time    [RING_DEPTH];
    logic [PAYLOAD_W-1:0] ring_payload [RING_DEPTH];
    int unsigned          ring_head  = 0;
    int unsigned          ring_count = 0;

    out_item_t  search_answers [$];
    in_item_t   pending_cmds   [$];
    int         error_count   = 0;
    int         counted_items = 0;
    int         cycle_count   = 0;
    int         gap_left      = 0;
    int         burst_left    = 0;
    out_item_t  answer_due;

    // Generator-side view of recent appends, used to aim search keys.
    logic [ID_W-1:0]   recent_ids   [$];
    logic [TIME_W-1:0] recent_times [$];
    longint            next_id;
    longint            next_time;

    function automatic string show_result(input out_item_t r);
        return $sformatf("found=%0d id=%h time=%h payload=%h fill=%0d",
                         r.found, r.rec_id, r.rec_time, r.rec_payload, r.fill_count);
    endfunction

    task automatic log_failure(input string msg);
        error_count++;
        if (error_count <= REPORT_LIMIT)
            $display("[%0t] %s", $realtime, msg);
    endtask

    task automatic predict_command(input in_item_t c);
        int unsigned slot;
        int unsigned base;
        int unsigned span;
        int unsigned half;
        logic [31:0] probe;
        logic [31:0] key;
        logic        by_id;
        out_item_t   answer;
        case (c.op)
            OP_APPEND:
            begin
                // Overwrite the oldest record once the ring is full.
                if (ring_count >= RING_DEPTH)
                begin
                    slot = ring_head;
                    ring_head = (ring_head + 1) % RING_DEPTH;
                end
                else
                begin
                    slot = (ring_head + ring_count) % RING_DEPTH;
                    ring_count++;
                end
                ring_id[slot]      = c.key_id;
                ring_time[slot]    = c.key_time;
                ring_payload[slot] = c.payload;
            end
            OP_FIND_TIME, OP_FIND_ID:
            begin
                by_id = (c.op == OP_FIND_ID);
                key   = by_id ? {1'b0, c.key_id} : c.key_time;
                base  = 0;
                span  = ring_count;
                while (span > 0)
                begin
                    half  = span / 2;
                    slot  = (ring_head + base + half) % RING_DEPTH;
                    probe = by_id ? {1'b0, ring_id[slot]} : ring_time[slot];
                    if (probe < key)
                    begin
                        base = base + half + 1;
                        span = span - half - 1;
                    end
                    else
                        span = half;
                end
                answer = '0;
                answer.fill_count = FILL_W'(ring_count);
                if (base < ring_count)
                begin
                    slot = (ring_head + base) % RING_DEPTH;
                    if (!by_id || ring_id[slot] == c.key_id)
                    begin
                        answer.found       = 1'b1;
                        answer.rec_id      = ring_id[slot];
                        answer.rec_time    = ring_time[slot];
                        answer.rec_payload = ring_payload[slot];
                    end
                end
                search_answers.insert(search_answers.size(), answer);
            end
            default: ;
        endcase
    endtask

    task automatic add_cmd(input logic [1:0] op, input logic [ID_W-1:0] id,
                           input logic [TIME_W-1:0] stamp,
                           input logic [PAYLOAD_W-1:0] payload);
        in_item_t item;
        item.op       = op;
        item.key_id   = id;
        item.key_time = stamp;
        item.payload  = payload;
        pending_cmds.insert(pending_cmds.size(), item);
        counted_items++;
        if (op == OP_APPEND)
        begin
            recent_ids.insert(recent_ids.size(), id);
            recent_times.insert(recent_times.size(), stamp);
            if (recent_ids.size() > RING_DEPTH)
            begin
                recent_ids.delete(0);
                recent_times.delete(0);
            end
        end
    endtask

    function automatic logic [PAYLOAD_W-1:0] random_payload();
        return {$urandom, $urandom};
    endfunction

    task automatic add_rising_append();
        next_id   = next_id + $urandom_range(1, 50);
        next_time = next_time + $urandom_range(1, 100000);
        // Wrap back to small values past the field range; the order breaks here.
        if (next_id > longint'(ID_MAX))
            next_id = $urandom_range(0, 1000);
        if (next_time > longint'(TIME_MAX))
            next_time = $urandom_range(0, 100000);
        add_cmd(OP_APPEND, ID_W'(next_id), TIME_W'(next_time), random_payload());
    endtask

    task automatic add_time_search();
        int unsigned pick;
        logic [TIME_W-1:0] stamp;
        pick  = $urandom_range(0, recent_times.size() - 1);
        stamp = recent_times[pick];
        case ($urandom_range(0, 4))
            0: stamp = stamp - 1;
            1: stamp = stamp + 1;
            2: stamp = $urandom;
            default: ;
        endcase
        add_cmd(OP_FIND_TIME, ID_W'($urandom), stamp, random_payload());
    endtask

    task automatic add_id_search();
        int unsigned pick;
        logic [ID_W-1:0] id;
        pick = $urandom_range(0, recent_ids.size() - 1);
        id   = recent_ids[pick];
        case ($urandom_range(0, 5))
            0: id = id - ID_W'(1);
            1: id = id + ID_W'(1);
            2: id = ID_W'($urandom);
            default: ;
        endcase
        add_cmd(OP_FIND_ID, id, $urandom, random_payload());
    endtask

    // Driver: present one transaction at a time, idle a random gap after each.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                predict_command(cmd);
                if (burst_left > 0)
                begin
                    burst_left--;
                    gap_left = 0;
                end
                else
                begin
                    gap_left = $urandom_range(0, 5);
                    if ($urandom_range(0, 9) == 0)
                        burst_left = $urandom_range(10, 40);
                end
                if (gap_left == 0 && pending_cmds.size() > 0)
                begin
                    cmd <= pending_cmds[0];
                    pending_cmds.delete(0);
                end
                else
                    start <= 1'b0;
            end
            else if (!start)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending_cmds.size() > 0)
                begin
                    cmd   <= pending_cmds[0];
                    pending_cmds.delete(0);
                    start <= 1'b1;
                end
            end
        end
    end

    // Monitor: each strobed result must match the oldest outstanding answer.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (search_answers.size() == 0)
                log_failure({"unexpected result: ", show_result(result)});
            else
            begin
                answer_due = search_answers[0];
                search_answers.delete(0);
                if (result.found !== answer_due.found ||
                    result.rec_id !== answer_due.rec_id ||
                    result.rec_time !== answer_due.rec_time ||
                    result.rec_payload !== answer_due.rec_payload ||
                    result.fill_count !== answer_due.fill_count)
                    log_failure({"mismatch: expected ", show_result(answer_due),
                                 " got ", show_result(result)});
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        int sel;

        // Empty table, field extremes, misses on both sides, unused op code.
        add_cmd(OP_FIND_TIME, '0, '0, '0);
        add_cmd(OP_FIND_ID, '0, TIME_MAX, '1);
        add_cmd(OP_APPEND, '0, '0, '0);
        add_cmd(OP_APPEND, 31'd5, 32'd100, '1);
        add_cmd(OP_FIND_TIME, '0, '0, '0);
        add_cmd(OP_FIND_TIME, '0, 32'd50, '0);
        add_cmd(OP_FIND_TIME, '0, 32'd100, '0);
        add_cmd(OP_FIND_TIME, ID_MAX, TIME_MAX, '0);
        add_cmd(OP_FIND_ID, 31'd5, '0, '0);
        add_cmd(OP_FIND_ID, 31'd3, '0, '0);
        add_cmd(OP_FIND_ID, ID_MAX, '0, '0);
        add_cmd(OP_APPEND, ID_MAX, TIME_MAX, random_payload());
        add_cmd(OP_FIND_TIME, '0, TIME_MAX, '0);
        add_cmd(OP_FIND_ID, ID_MAX, '0, '1);
        add_cmd(OP_UNUSED, ID_MAX, TIME_MAX, '1);
        add_cmd(OP_FIND_ID, ID_MAX, '0, '0);
        // Out-of-order record: search still follows insertion order.
        add_cmd(OP_APPEND, 31'd2, 32'd50, random_payload());
        add_cmd(OP_FIND_ID, 31'd2, '0, '0);
        add_cmd(OP_FIND_TIME, '0, 32'd50, '0);
        add_cmd(OP_FIND_TIME, '0, 32'd101, '0);

        next_id   = $urandom_range(0, 1000);
        next_time = $urandom_range(0, 100000);
        while (counted_items < RANDOM_ITEMS)
        begin
            // Occasionally jump the sequence to a random base.
            if ($urandom_range(0, 99) < 3)
            begin
                next_id   = $urandom & ID_MAX;
                next_time = $urandom;
            end
            sel = $urandom_range(0, 99);
            if (sel < 45)
            begin
                if ($urandom_range(0, 99) < 4)
                    add_cmd(OP_APPEND, ID_W'($urandom), $urandom, random_payload());
                else
                    add_rising_append();
            end
            else if (sel < 65)
                add_time_search();
            else if (sel < 88)
                add_id_search();
            else if (sel < 92)
                add_cmd(OP_UNUSED, ID_W'($urandom), $urandom, random_payload());
            else if (sel < 96)
                add_cmd(OP_FIND_TIME, ID_W'($urandom), $urandom, random_payload());
            else
                add_cmd(OP_FIND_ID, ID_W'($urandom), $urandom, random_payload());
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_cmds.size() > 0 || start)
            @(posedge clk);
        while (search_answers.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (search_answers.size() > 0)
            log_failure($sformatf("%0d results never arrived", search_answers.size()));

        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
